// ===== src/fdmd_pkg.sv =====
// Package of the frame-difference motion detector.
// Holds the gray conversion constants, the result field widths and the result type.
// No dependencies.
package fdmd_pkg;

  // Gray weights; the weighted sum is divided by 100 through a reciprocal.
  localparam int GRAY_WR     = 30;
  localparam int GRAY_WG     = 59;
  localparam int GRAY_WB     = 11;
  localparam int WSUM_W      = 15;     // 100 * 255 fits in 15 bits
  localparam int GRAY_RECIP  = 41944;  // ceil(2^22 / 100), exact for sums up to 25500
  localparam int GRAY_SHIFT  = 22;
  localparam int GRAY_PROD_W = 31;
  localparam int GRAY_W      = 8;

  // Detection constants.
  localparam int SCALE_SUM   = 100;
  localparam int SCALE_FULL  = 255;
  localparam int THR_W       = 7;
  localparam logic [THR_W-1:0] THR_RESET = 7'd8;

  // Result field widths and their saturation values.
  localparam int OUT_SUM_W = 20;
  localparam int OUT_CNT_W = 12;
  localparam logic [OUT_SUM_W-1:0] OUT_SUM_MAX = 20'hFFFFF;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 12'hFFF;

  // Result queue.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_OCC_W = 3;

  typedef struct packed {
    logic                 first_frame;
    logic                 motion_detected;
    logic [OUT_CNT_W-1:0] compared_count;
    logic [OUT_SUM_W-1:0] difference_sum;
  } result_t;

endpackage

// ===== src/frame_difference_motion_detector_core.sv =====
// Top level of the frame-difference motion detector.
// Depends on fdmd_pkg and on fdmd_ram for the previous-frame store.
//
// The block takes one RGB pixel per clock in raster order and ends a frame with the
// pixel that carries tlast. Each pixel is turned into gray, compared against the gray
// value stored at the same index for the previous frame, and written back in place, so
// the store always holds the latest frame. The previous-frame store has one read and
// one write port: a pixel reads its entry in the cycle it is accepted and writes the
// new gray value in the cycle after. When a one-pixel frame is followed directly by the
// next frame, the value still being written is forwarded instead of the stale read.
// The sustained rate is one pixel per cycle. Each frame produces exactly one result
// transaction after its last pixel has passed through stages 1, 2 and 3; results wait in a
// four-entry queue, and the input is held off only while the queue together with the
// results still in flight could fill it, which costs cycles only when the output side
// stalls or one-pixel frames follow each other. The first frame after reset is only
// stored and reports first_frame with zero sum, count and detection. Pixels beyond the
// store capacity are ignored except for their tlast. The store needs no clearing pass
// after reset, since only entries written by the previous frame are ever compared.
module frame_difference_motion_detector_core #(
  parameter int FRAME_PIXELS = 3072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: threshold_percent.
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // Pixel input.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tlast_i,   // last_pixel
  // Result output.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // difference_sum [19:0], compared_count [31:20],
                                        // motion_detected [32], zero fill [39:33]
  output logic        m_axis_tuser_o    // first_frame
);

  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int CNT_W  = $clog2(FRAME_PIXELS + 1);
  localparam int SUM_W  = $clog2(255 * FRAME_PIXELS + 1);
  localparam int TC_W   = fdmd_pkg::THR_W + CNT_W;
  localparam int DET_A  = SUM_W + 7;
  localparam int DET_B  = TC_W + 8;
  localparam int DET_W  = (DET_A > DET_B) ? DET_A : DET_B;
  localparam int SUM_XW = (SUM_W > fdmd_pkg::OUT_SUM_W) ? SUM_W : fdmd_pkg::OUT_SUM_W;
  localparam int CNT_XW = (CNT_W > fdmd_pkg::OUT_CNT_W) ? CNT_W : fdmd_pkg::OUT_CNT_W;

  // ------------------------------------------------------------------
  // Configuration register.
  // ------------------------------------------------------------------
  logic [fdmd_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fdmd_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------------------
  // Accept stage: frame bookkeeping, store read and weighted sum.
  // ------------------------------------------------------------------
  logic                        s_acc;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            prev_cnt_q, prev_cnt_d;
  logic                        have_prev_q, have_prev_d;
  logic                        in_range, cmp_pix;
  logic [CNT_W-1:0]            count_now, min_cnt;
  logic [fdmd_pkg::WSUM_W-1:0] wsum;
  logic [7:0]                  px_r, px_g, px_b;

  assign px_r = s_axis_tdata_i[7:0];
  assign px_g = s_axis_tdata_i[15:8];
  assign px_b = s_axis_tdata_i[23:16];

  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range  = idx_q < CNT_W'(FRAME_PIXELS);
  assign cmp_pix   = have_prev_q && (idx_q < prev_cnt_q);
  assign count_now = idx_q + CNT_W'(in_range);
  assign min_cnt   = (prev_cnt_q < count_now) ? prev_cnt_q : count_now;

  assign wsum = fdmd_pkg::WSUM_W'(px_r) * fdmd_pkg::WSUM_W'(fdmd_pkg::GRAY_WR)
              + fdmd_pkg::WSUM_W'(px_g) * fdmd_pkg::WSUM_W'(fdmd_pkg::GRAY_WG)
              + fdmd_pkg::WSUM_W'(px_b) * fdmd_pkg::WSUM_W'(fdmd_pkg::GRAY_WB);

  always_comb begin
    idx_d       = idx_q;
    prev_cnt_d  = prev_cnt_q;
    have_prev_d = have_prev_q;
    if (s_acc) begin
      if (s_axis_tlast_i) begin
        idx_d       = '0;
        prev_cnt_d  = count_now;
        have_prev_d = 1'b1;
      end else begin
        idx_d = count_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      prev_cnt_q  <= '0;
      have_prev_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      prev_cnt_q  <= prev_cnt_d;
      have_prev_q <= have_prev_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: gray value, difference against the stored pixel, write-back.
  // ------------------------------------------------------------------
  logic                        s1_valid_q;
  logic [fdmd_pkg::WSUM_W-1:0] s1_wsum_q;
  logic                        s1_wr_q, s1_cmp_q, s1_last_q, s1_first_q, s1_mis_q;
  logic [ADDR_W-1:0]           s1_addr_q;
  logic [CNT_W-1:0]            s1_min_q;
  logic                        fwd_q;
  logic                        s1_we;
  logic [fdmd_pkg::GRAY_PROD_W-1:0] gray_prod;
  logic [fdmd_pkg::GRAY_W-1:0] s1_gray, s1_old, ram_rdata, s1_diff;
  logic [fdmd_pkg::GRAY_W-1:0] s2_gray_q;

  assign s1_we = s1_valid_q && s1_wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= s_acc;
      // The entry read now is being written this cycle by the pixel ahead.
      fwd_q      <= s_acc && s1_we && (s1_addr_q == idx_q[ADDR_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_wsum_q  <= wsum;
      s1_wr_q    <= in_range;
      s1_cmp_q   <= cmp_pix;
      s1_last_q  <= s_axis_tlast_i;
      s1_first_q <= !have_prev_q;
      s1_mis_q   <= prev_cnt_q != count_now;
      s1_min_q   <= have_prev_q ? min_cnt : '0;
      s1_addr_q  <= idx_q[ADDR_W-1:0];
    end
  end

  fdmd_ram #(
    .WIDTH (fdmd_pkg::GRAY_W),
    .DEPTH (FRAME_PIXELS)
  ) u_prev_frame (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_gray),
    .re_i    (s_acc),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign gray_prod = fdmd_pkg::GRAY_PROD_W'(s1_wsum_q)
                   * fdmd_pkg::GRAY_PROD_W'(fdmd_pkg::GRAY_RECIP);
  assign s1_gray   = gray_prod[fdmd_pkg::GRAY_SHIFT +: fdmd_pkg::GRAY_W];
  assign s1_old    = fwd_q ? s2_gray_q : ram_rdata;
  assign s1_diff   = (s1_old > s1_gray) ? (s1_old - s1_gray) : (s1_gray - s1_old);

  // ------------------------------------------------------------------
  // Stage 2: accumulation and threshold product.
  // ------------------------------------------------------------------
  logic                        s2_valid_q, s2_last_q, s2_first_q, s2_mis_q;
  logic [fdmd_pkg::GRAY_W-1:0] s2_diff_q;
  logic [CNT_W-1:0]            s2_min_q;
  logic [SUM_W-1:0]            sum_q, sum_d, sum_total;
  logic [TC_W-1:0]             s2_tc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_gray_q  <= s1_gray;
      s2_diff_q  <= s1_cmp_q ? s1_diff : '0;
      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
      s2_mis_q   <= s1_mis_q;
      s2_min_q   <= s1_min_q;
    end
  end

  assign sum_total = sum_q + SUM_W'(s2_diff_q);
  assign s2_tc     = TC_W'(thr_q) * TC_W'(s2_min_q);

  always_comb begin
    sum_d = sum_q;
    if (s2_valid_q) begin
      sum_d = s2_last_q ? '0 : sum_total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: detection compare and saturation into the result fields.
  // ------------------------------------------------------------------
  logic                 s3_valid_q, s3_first_q, s3_mis_q;
  logic [SUM_W-1:0]     s3_sum_q;
  logic [CNT_W-1:0]     s3_min_q;
  logic [TC_W-1:0]      s3_tc_q;
  logic [DET_W-1:0]     det_lhs, det_rhs;
  logic [SUM_XW-1:0]    sum_ext;
  logic [CNT_XW-1:0]    cnt_ext;
  fdmd_pkg::result_t    res_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_last_q) begin
      s3_sum_q   <= sum_total;
      s3_min_q   <= s2_min_q;
      s3_tc_q    <= s2_tc;
      s3_first_q <= s2_first_q;
      s3_mis_q   <= s2_mis_q;
    end
  end

  assign det_lhs = DET_W'(s3_sum_q) * DET_W'(fdmd_pkg::SCALE_SUM);
  assign det_rhs = DET_W'(s3_tc_q) * DET_W'(fdmd_pkg::SCALE_FULL);
  assign sum_ext = SUM_XW'(s3_sum_q);
  assign cnt_ext = CNT_XW'(s3_min_q);

  always_comb begin
    res_new.first_frame     = s3_first_q;
    res_new.motion_detected = !s3_first_q && ((det_lhs >= det_rhs) || s3_mis_q);
    // The first frame has no comparisons, so its sum and count are already zero.
    res_new.difference_sum  = (sum_ext > SUM_XW'(fdmd_pkg::OUT_SUM_MAX)) ?
                              fdmd_pkg::OUT_SUM_MAX : sum_ext[fdmd_pkg::OUT_SUM_W-1:0];
    res_new.compared_count  = (cnt_ext > CNT_XW'(fdmd_pkg::OUT_CNT_MAX)) ?
                              fdmd_pkg::OUT_CNT_MAX : cnt_ext[fdmd_pkg::OUT_CNT_W-1:0];
  end

  // ------------------------------------------------------------------
  // Result queue. The input is held off whenever the results already queued plus
  // those still in the pipeline could leave no room for one more.
  // ------------------------------------------------------------------
  fdmd_pkg::result_t            res_q [fdmd_pkg::RES_DEPTH];
  logic [fdmd_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [fdmd_pkg::RES_OCC_W-1:0] occ_q, occ_d, pending;
  logic                           push, pop;
  fdmd_pkg::result_t              res_head;

  assign push    = s3_valid_q;
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign pending = occ_q
                 + fdmd_pkg::RES_OCC_W'(s1_valid_q && s1_last_q)
                 + fdmd_pkg::RES_OCC_W'(s2_valid_q && s2_last_q)
                 + fdmd_pkg::RES_OCC_W'(s3_valid_q);
  assign s_axis_tready_o = pending < fdmd_pkg::RES_OCC_W'(fdmd_pkg::RES_DEPTH);

  always_comb begin
    occ_d = occ_q;
    case ({push, pop})
      2'b10:   occ_d = occ_q + 1'b1;
      2'b01:   occ_d = occ_q - 1'b1;
      default: occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

  assign res_head        = res_q[rd_ptr_q];
  assign m_axis_tvalid_o = occ_q != '0;
  assign m_axis_tdata_o  = {7'd0, res_head.motion_detected, res_head.compared_count,
                            res_head.difference_sum};
  assign m_axis_tuser_o  = res_head.first_frame;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= fdmd_pkg::RES_OCC_W'(fdmd_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (occ_q != fdmd_pkg::RES_OCC_W'(fdmd_pkg::RES_DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_fwd_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && s2_valid_q)
    else $error("forwarding without a pixel ahead in the pipeline");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (idx_q == '0) && have_prev_q)
    else $error("pixel index not restarted after the last pixel");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q <= CNT_W'(FRAME_PIXELS)) && (prev_cnt_q <= CNT_W'(FRAME_PIXELS)))
    else $error("pixel index beyond store capacity");

endmodule

// ===== src/fdmd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/frame_difference_motion_detector_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of frame_difference_motion_detector_core: directed and random
// pixel frames under random input gaps and output stalls, each result checked in order.
// Depends on fdmd_pkg and the detector RTL; needs nothing else.
module frame_difference_motion_detector_core_tb;

  localparam int FRAME_PIXELS   = 3072;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  // Quiet cycles waited out once every result is in, well beyond the block's pipeline.
  localparam int SETTLE_CYCLES  = 16;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS  = 790;
  localparam int PHASE_PIXELS   = 190;
  // Random frames never exceed this length, so their content can be remembered.
  localparam int HISTORY        = 64;
  // Room for predicted results that are not yet checked.
  localparam int EXP_DEPTH      = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // red [7:0], green [15:8], blue [23:16]
  logic        s_axis_tlast_i;   // last_pixel
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // difference_sum [19:0], compared_count [31:20],
                                 // motion_detected [32], zero fill [39:33]
  logic        m_axis_tuser_o;   // first_frame

  frame_difference_motion_detector_core #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Shadow of the detector: gray store, frame counters and threshold.
  logic [fdmd_pkg::GRAY_W-1:0] gray_store [FRAME_PIXELS];
  int unsigned                 stored_count;
  int unsigned                 pixel_pos;
  int unsigned                 diff_accum;
  bit                          have_stored_frame;
  logic [fdmd_pkg::THR_W-1:0]  threshold_pct;
  fdmd_pkg::result_t           expected_results [EXP_DEPTH];
  int unsigned                 exp_wr_cnt;
  int unsigned                 exp_rd_cnt;
  fdmd_pkg::result_t           awaited;
  int unsigned                 mismatches;

  // Sender burst state and the content of the last random frame.
  int                burst_left;
  bit                no_gaps;
  logic [7:0]        hist_r [HISTORY];
  logic [7:0]        hist_g [HISTORY];
  logic [7:0]        hist_b [HISTORY];
  int unsigned       last_len;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Folds one accepted pixel into the shadow state and queues the frame result on tlast.
  function automatic void score_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic last);
    int unsigned       gray;
    int unsigned       old;
    int unsigned       cmp_n;
    longint unsigned   lhs;
    longint unsigned   rhs;
    fdmd_pkg::result_t res;
    gray = (fdmd_pkg::GRAY_WR * int'(r) + fdmd_pkg::GRAY_WG * int'(g)
            + fdmd_pkg::GRAY_WB * int'(b)) / fdmd_pkg::SCALE_SUM;
    // Pixels past the store capacity are dropped; only their tlast matters.
    if (pixel_pos < FRAME_PIXELS) begin
      if (have_stored_frame && pixel_pos < stored_count) begin
        old = gray_store[pixel_pos];
        diff_accum += (old > gray) ? old - gray : gray - old;
      end
      gray_store[pixel_pos] = fdmd_pkg::GRAY_W'(gray);
      pixel_pos++;
    end
    if (last) begin
      res = '0;
      res.first_frame = !have_stored_frame;
      if (have_stored_frame) begin
        cmp_n = (stored_count < pixel_pos) ? stored_count : pixel_pos;
        lhs = longint'(diff_accum) * fdmd_pkg::SCALE_SUM;
        rhs = longint'(threshold_pct) * cmp_n * fdmd_pkg::SCALE_FULL;
        // A change of frame size counts as motion whatever the threshold.
        res.motion_detected = (lhs >= rhs) || (stored_count != pixel_pos);
        res.difference_sum  = (diff_accum > fdmd_pkg::OUT_SUM_MAX) ?
                              fdmd_pkg::OUT_SUM_MAX : fdmd_pkg::OUT_SUM_W'(diff_accum);
        res.compared_count  = (cmp_n > fdmd_pkg::OUT_CNT_MAX) ?
                              fdmd_pkg::OUT_CNT_MAX : fdmd_pkg::OUT_CNT_W'(cmp_n);
      end
      expected_results[exp_wr_cnt % EXP_DEPTH] = res;
      exp_wr_cnt++;
      stored_count      = pixel_pos;
      have_stored_frame = 1'b1;
      pixel_pos         = 0;
      diff_accum        = 0;
    end
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] base, int amp);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * amp)) - amp;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Sends one pixel transaction. The sender runs in bursts with idle gaps between them;
  // tvalid stays high from one pixel to the next inside a burst.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, g, r};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    score_pixel(r, g, b, last);
  endtask

  task automatic send_flat_frame(int len, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    for (int i = 0; i < len; i++) send_pixel(r, g, b, i == len - 1);
  endtask

  // One pixel of the given gray level leads a frame that is black otherwise.
  task automatic send_spot_frame(int len, logic [7:0] level);
    for (int i = 0; i < len; i++) begin
      if (i == 0) send_pixel(level, level, level, i == len - 1);
      else send_pixel(8'd0, 8'd0, 8'd0, i == len - 1);
    end
  endtask

  // Leaves the block idle: input low, every result in, then a few quiet cycles.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [fdmd_pkg::THR_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    threshold_pct = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The first frame after reset is only stored and reports first_frame alone.
  task automatic test_first_frame();
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
  endtask

  // Inverted colors give the largest differences; repeating them gives none.
  task automatic test_color_extremes();
    repeat (2) begin
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0,   1'b1);
    end
  endtask

  task automatic test_size_change();
    send_flat_frame(3, 8'd10, 8'd20, 8'd30);
    send_flat_frame(7, 8'd10, 8'd20, 8'd30);
  endtask

  // Back-to-back one-pixel frames exercise the forwarding of the pending store write.
  task automatic test_single_pixel_frames();
    no_gaps    = 1'b1;
    burst_left = 0;
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    send_pixel(8'd200, 8'd17,  8'd99,  1'b1);
    send_pixel(8'd1,   8'd254, 8'd128, 1'b1);
    no_gaps    = 1'b0;
  endtask

  // Sums right at and just below the threshold, then threshold 1, 0, 127 and 100.
  task automatic test_threshold_edges();
    write_threshold(7'd10);
    // Ten pixels at 10 percent put the edge at a sum of 255.
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    send_spot_frame(10, 8'd255);
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    send_spot_frame(10, 8'd254);
    write_threshold(7'd1);
    // A sum of 254 clears 1 percent; one gray step over 10 pixels does not.
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    send_spot_frame(10, 8'd1);
    write_threshold(7'd0);
    // With a zero threshold even identical frames are detected.
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    write_threshold(7'd127);
    // Above 100 percent even the full-scale difference is not detected.
    send_flat_frame(10, 8'd255, 8'd255, 8'd255);
    write_threshold(7'd100);
    // The full-scale difference sits exactly on the 100 percent edge.
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    send_flat_frame(10, 8'd0, 8'd0, 8'd0);
    write_threshold(fdmd_pkg::THR_RESET);
  endtask

  // Mostly frames of the same length whose content drifts a little from the last one,
  // so the threshold decides; some frames change length or are fully random.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned since_cfg;
    int          len;
    int          amp;
    bit          similar;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    sent      = 0;
    since_cfg = 0;
    last_len  = 8;
    for (int i = 0; i < HISTORY; i++) begin
      hist_r[i] = '0;
      hist_g[i] = '0;
      hist_b[i] = '0;
    end
    while (sent < RANDOM_PIXELS) begin
      if (since_cfg >= PHASE_PIXELS) begin
        case ($urandom_range(0, 4))
          0:       write_threshold(7'd0);
          1:       write_threshold(7'd100);
          2:       write_threshold(7'd127);
          3:       write_threshold(fdmd_pkg::THR_W'($urandom_range(1, 20)));
          default: write_threshold(fdmd_pkg::THR_W'($urandom_range(0, 127)));
        endcase
        since_cfg = 0;
      end
      if ($urandom_range(0, 9) < 7) len = last_len;
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(25, HISTORY);
      else len = $urandom_range(1, 24);
      similar = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 3))
        0:       amp = 0;
        1:       amp = 2;
        2:       amp = 8;
        default: amp = 40;
      endcase
      for (int i = 0; i < len; i++) begin
        if (similar) begin
          r = jitter(hist_r[i], amp);
          g = jitter(hist_g[i], amp);
          b = jitter(hist_b[i], amp);
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        hist_r[i] = r;
        hist_g[i] = g;
        hist_b[i] = b;
        send_pixel(r, g, b, i == len - 1);
      end
      last_len   = len;
      sent      += len;
      since_cfg += len;
    end
  endtask

  // Output side: stretches of steady ready, random ready, long stalls and toggling.
  initial begin
    int mode;
    int span;
    m_axis_tready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= (i >= span / 2);
          default: m_axis_tready_i <= i[0];
        endcase
      end
    end
  end

  // Each result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        report_mismatch("unexpected result, tdata", 64'(m_axis_tdata_o), 64'd0);
      end else begin
        awaited = expected_results[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (m_axis_tdata_o[fdmd_pkg::OUT_SUM_W-1:0] !== awaited.difference_sum)
          report_mismatch("difference_sum", 64'(m_axis_tdata_o[fdmd_pkg::OUT_SUM_W-1:0]),
                          64'(awaited.difference_sum));
        if (m_axis_tdata_o[fdmd_pkg::OUT_SUM_W +: fdmd_pkg::OUT_CNT_W]
            !== awaited.compared_count)
          report_mismatch("compared_count",
                          64'(m_axis_tdata_o[fdmd_pkg::OUT_SUM_W +: fdmd_pkg::OUT_CNT_W]),
                          64'(awaited.compared_count));
        if (m_axis_tdata_o[fdmd_pkg::OUT_SUM_W+fdmd_pkg::OUT_CNT_W]
            !== awaited.motion_detected)
          report_mismatch("motion_detected",
                          64'(m_axis_tdata_o[fdmd_pkg::OUT_SUM_W+fdmd_pkg::OUT_CNT_W]),
                          64'(awaited.motion_detected));
        if (m_axis_tuser_o !== awaited.first_frame)
          report_mismatch("first_frame", 64'(m_axis_tuser_o), 64'(awaited.first_frame));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    s_axis_tvalid_i   = 1'b0;
    s_axis_tdata_i    = '0;
    s_axis_tlast_i    = 1'b0;
    stored_count      = 0;
    pixel_pos         = 0;
    diff_accum        = 0;
    have_stored_frame = 1'b0;
    threshold_pct     = fdmd_pkg::THR_RESET;
    exp_wr_cnt        = 0;
    exp_rd_cnt        = 0;
    mismatches        = 0;
    burst_left        = 0;
    no_gaps           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_first_frame();
    test_color_extremes();
    test_size_change();
    test_single_pixel_frames();
    test_threshold_edges();
    test_random_frames();

    drain_results();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
src/fdmd_pkg.sv
src/fdmd_ram.sv
src/frame_difference_motion_detector_core.sv
tb/frame_difference_motion_detector_core_tb.sv
